// ===== rtl/escape_time_fractal_pixel_core_macros.svh =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel core - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_MACROS_SVH

// property must hold at every clock edge out of reset
`define ETFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define ETFP_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/etfp_pkg.sv =====
// ----------------------------------------------------------------------------
// etfp_pkg
// Types, constants and helpers of the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package etfp_pkg;

  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned ITER_W     = 10;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned MAG_W      = 34;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 34;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd7;

  localparam logic [31:0]         RST_ZOOM  = 32'h1000_0000;
  localparam logic [ITER_W-1:0]   RST_ITER  = 10'd64;
  localparam logic [MAG_W-1:0]    RST_LIMIT = 34'h0_4000_0000;
  localparam logic [COLOR_W-1:0]  WHITE_RGB = 24'hFF_FFFF;

  // 2.0 in Q4.28, held in the 40-bit working width
  localparam logic signed [39:0]  TWO_Q = 40'sd2 <<< FRAC_BITS;

  // sequencing
  localparam int unsigned CNT_W             = 3;
  localparam int unsigned MAP_CYCLES        = 5;
  localparam int unsigned DIV_BITS_PER_STEP = 4;
  localparam int unsigned DIV_STEPS         = COLOR_W / DIV_BITS_PER_STEP;
  localparam logic [CNT_W-1:0] MAP_LAST = CNT_W'(MAP_CYCLES - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic                     julia_mode;
    logic [31:0]              zoom_factor;
    logic signed [31:0]       offset_re;
    logic signed [31:0]       offset_im;
    logic signed [31:0]       julia_re;
    logic signed [31:0]       julia_im;
    logic [ITER_W-1:0]        max_iter;
    logic [MAG_W-1:0]         escape_limit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic iter_start;
    logic iter_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic esc_hit;
    logic lim_hit;
  } stat_t;

  function automatic logic signed [39:0] sext40(input logic signed [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  // clamp a 40-bit signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic [8:0] hi;
    hi = v[39:31];
    if (hi == 9'h000 || hi == 9'h1FF) begin
      return v[31:0];
    end else if (v[39]) begin
      return {1'b1, 31'h0};
    end else begin
      return {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/etfp_cfg.sv =====
// ----------------------------------------------------------------------------
// etfp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module etfp_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [etfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [etfp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output etfp_pkg::cfg_t                           cfg_o
);

  etfp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        etfp_pkg::REG_JULIA_MODE:   cfg_d.julia_mode   = cfg_wdata_i[0];
        etfp_pkg::REG_ZOOM_FACTOR:  cfg_d.zoom_factor  = cfg_wdata_i[31:0];
        etfp_pkg::REG_OFFSET_RE:    cfg_d.offset_re    = cfg_wdata_i[31:0];
        etfp_pkg::REG_OFFSET_IM:    cfg_d.offset_im    = cfg_wdata_i[31:0];
        etfp_pkg::REG_JULIA_RE:     cfg_d.julia_re     = cfg_wdata_i[31:0];
        etfp_pkg::REG_JULIA_IM:     cfg_d.julia_im     = cfg_wdata_i[31:0];
        etfp_pkg::REG_MAX_ITER:     cfg_d.max_iter     = cfg_wdata_i[etfp_pkg::ITER_W-1:0];
        etfp_pkg::REG_ESCAPE_LIMIT: cfg_d.escape_limit = cfg_wdata_i[etfp_pkg::MAG_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.zoom_factor  <= etfp_pkg::RST_ZOOM;
      cfg_q.max_iter     <= etfp_pkg::RST_ITER;
      cfg_q.escape_limit <= etfp_pkg::RST_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/etfp_map.sv =====
// ----------------------------------------------------------------------------
// etfp_map
// One coordinate lane: pixel index to Q4.28 plane value, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module etfp_map #(
  parameter int unsigned DIM    = 1024,
  parameter bit          INVERT = 1'b0
) (
  input  wire logic                              clk_i,
  input  wire logic [etfp_pkg::COORD_W-1:0]      coord_i,
  input  wire logic [31:0]                       zoom_i,
  input  wire logic signed [31:0]                offset_i,
  output logic signed [31:0]                     z0_o
);

  // (coord << 30) / DIM = coord*QA + floor(coord*RB / DIM), with 2^30 = DIM*QA + RB
  localparam longint unsigned UNIT   = 64'd1 << (etfp_pkg::FRAC_BITS + 2);
  localparam longint unsigned QA     = UNIT / DIM;
  localparam longint unsigned RB     = UNIT % DIM;
  localparam int unsigned     QA_W   = $clog2(QA + 1);
  localparam int unsigned     RB_W   = $clog2(DIM);
  localparam int unsigned     NB_W   = etfp_pkg::COORD_W + RB_W;
  localparam int unsigned     RSH    = etfp_pkg::COORD_W + 2 * RB_W;
  localparam longint unsigned RECIP  = ((64'd1 << RSH) + DIM - 1) / DIM;
  localparam int unsigned     RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned     Q_W    = etfp_pkg::COORD_W + QA_W + 1;

  localparam logic [QA_W-1:0]    QA_C    = QA_W'(QA);
  localparam logic [RB_W-1:0]    RB_C    = RB_W'(RB);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [Q_W-1:0]              qa_q;
  logic [NB_W-1:0]             nb_q;
  logic [Q_W-1:0]              q_q;
  logic signed [63:0]          p_q;
  logic signed [31:0]          z0_q;

  logic [NB_W+RECIP_W-1:0]     frac_prod;
  logic signed [39:0]          q_s;
  logic signed [39:0]          unit_s;
  logic signed [31:0]          unit_sat;
  logic signed [32:0]          zoom_s;
  logic signed [64:0]          p_full;
  logic signed [63:0]          p_sh;
  logic signed [31:0]          scaled;
  logic signed [39:0]          shifted_sum;

  always_comb begin
    frac_prod   = nb_q * RECIP_C;
    q_s         = $signed(40'(q_q));
    unit_s      = INVERT ? (etfp_pkg::TWO_Q - q_s) : (q_s - etfp_pkg::TWO_Q);
    unit_sat    = etfp_pkg::sat32(unit_s);
    zoom_s      = $signed({1'b0, zoom_i});
    p_full      = unit_sat * zoom_s;
    p_sh        = p_q >>> etfp_pkg::FRAC_BITS;
    scaled      = etfp_pkg::sat32($signed(p_sh[39:0]));
    shifted_sum = etfp_pkg::sext40(scaled) + etfp_pkg::sext40(offset_i);
  end

  always_ff @(posedge clk_i) begin
    qa_q <= Q_W'(coord_i) * QA_C;
    nb_q <= NB_W'(coord_i) * RB_C;
    q_q  <= qa_q + Q_W'(frac_prod >> RSH);
    p_q  <= p_full[63:0];
    z0_q <= etfp_pkg::sat32(shifted_sum);
  end

  assign z0_o = z0_q;

endmodule

`default_nettype wire

// ===== rtl/etfp_dp.sv =====
// ----------------------------------------------------------------------------
// etfp_dp
// Datapath: coordinate lanes, z*z+c iteration, colour divider, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module etfp_dp #(
  parameter int unsigned IMG_WIDTH  = 1024,
  parameter int unsigned IMG_HEIGHT = 1024
) (
  input  wire logic                              clk_i,
  input  wire etfp_pkg::cfg_t                    cfg_i,
  input  wire etfp_pkg::cmd_t                    cmd_i,
  output etfp_pkg::stat_t                        stat_o,
  input  wire logic [etfp_pkg::COORD_W-1:0]      pixel_x_i,
  input  wire logic [etfp_pkg::COORD_W-1:0]      pixel_y_i,
  output logic [etfp_pkg::COORD_W-1:0]           out_x_o,
  output logic [etfp_pkg::COORD_W-1:0]           out_y_o,
  output logic [etfp_pkg::COLOR_W-1:0]           pixel_color_o,
  output logic                                   escaped_o
);

  localparam int unsigned CW      = etfp_pkg::COLOR_W;
  localparam int unsigned IW      = etfp_pkg::ITER_W;
  localparam int unsigned MAG_W_L = etfp_pkg::MAG_W;

  logic [etfp_pkg::COORD_W-1:0] px_q, py_q;
  logic signed [31:0]           z0r, z0i;

  etfp_map #(.DIM(IMG_WIDTH), .INVERT(1'b0)) u_map_x (
    .clk_i    (clk_i),
    .coord_i  (px_q),
    .zoom_i   (cfg_i.zoom_factor),
    .offset_i (cfg_i.offset_re),
    .z0_o     (z0r)
  );

  etfp_map #(.DIM(IMG_HEIGHT), .INVERT(1'b1)) u_map_y (
    .clk_i    (clk_i),
    .coord_i  (py_q),
    .zoom_i   (cfg_i.zoom_factor),
    .offset_i (cfg_i.offset_im),
    .z0_o     (z0i)
  );

  // iteration: product registers hold zr*zr, zi*zi, zr*zi of the current z
  logic signed [63:0] rr_q, ii_q, ri_q;
  logic [IW-1:0]      iter_q;

  logic signed [31:0] cr, ci;
  logic signed [63:0] re_diff, re_sh, im_sh;
  logic signed [31:0] znr, zni, sel_r, sel_i;
  logic [63:0]        mag_sum;
  logic [MAG_W_L-1:0] mag;

  always_comb begin
    cr      = cfg_i.julia_mode ? cfg_i.julia_re : z0r;
    ci      = cfg_i.julia_mode ? cfg_i.julia_im : z0i;
    re_diff = rr_q - ii_q;
    re_sh   = re_diff >>> etfp_pkg::FRAC_BITS;
    im_sh   = ri_q >>> (etfp_pkg::FRAC_BITS - 1);
    znr     = etfp_pkg::sat32($signed(re_sh[39:0]) + etfp_pkg::sext40(cr));
    zni     = etfp_pkg::sat32($signed(im_sh[39:0]) + etfp_pkg::sext40(ci));
    sel_r   = cmd_i.iter_start ? z0r : znr;
    sel_i   = cmd_i.iter_start ? z0i : zni;
    // both squares are non-negative, so the sum fits unsigned 64 bits
    mag_sum = rr_q + ii_q;
    if (|mag_sum[63:etfp_pkg::FRAC_BITS+MAG_W_L]) begin
      mag = '1;
    end else begin
      mag = mag_sum[etfp_pkg::FRAC_BITS +: MAG_W_L];
    end
  end

  assign stat_o.esc_hit = (iter_q != '0) && (mag > cfg_i.escape_limit);
  assign stat_o.lim_hit = (iter_q == cfg_i.max_iter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_start || cmd_i.iter_step) begin
      rr_q <= sel_r * sel_r;
      ii_q <= sel_i * sel_i;
      ri_q <= sel_r * sel_i;
    end
    if (cmd_i.iter_start) begin
      iter_q <= '0;
    end else if (cmd_i.iter_step) begin
      iter_q <= iter_q + IW'(1);
    end
  end

  // colour = i * 0xFFFFFF / max_iter, restoring divide, several bits a cycle
  logic [IW-1:0]      rem_q, rem_n;
  logic [CW-1:0]      low_q, low_n;
  logic [IW-1:0]      esc_i;
  logic [IW+CW-1:0]   numer;
  logic [IW:0]        trial;
  logic               ge;
  logic               res_esc_q;

  always_comb begin
    esc_i = iter_q - IW'(1);
    numer = {esc_i, {CW{1'b0}}} - (IW+CW)'(esc_i);
    rem_n = rem_q;
    low_n = low_q;
    trial = '0;
    ge    = 1'b0;
    for (int k = 0; k < etfp_pkg::DIV_BITS_PER_STEP; k++) begin
      trial = {rem_n, low_n[CW-1]};
      ge    = (trial >= {1'b0, cfg_i.max_iter});
      low_n = {low_n[CW-2:0], ge};
      rem_n = ge ? IW'(trial - {1'b0, cfg_i.max_iter}) : trial[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q      <= pixel_x_i;
      py_q      <= pixel_y_i;
      res_esc_q <= 1'b0;
    end
    if (cmd_i.div_start) begin
      rem_q     <= numer[IW+CW-1:CW];
      low_q     <= numer[CW-1:0];
      res_esc_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      low_q <= low_n;
    end
  end

  // output register
  logic [etfp_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic [CW-1:0]                color_q;
  logic                         esc_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      color_q   <= res_esc_q ? low_q : etfp_pkg::WHITE_RGB;
      esc_out_q <= res_esc_q;
    end
  end

  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign pixel_color_o = color_q;
  assign escaped_o     = esc_out_q;

endmodule

`default_nettype wire

// ===== rtl/etfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer: request handshakes, mapping wait, iteration loop, divide, output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escape_time_fractal_pixel_core_macros.svh"

module etfp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire etfp_pkg::stat_t stat_i,
  output etfp_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAP  = 3'd1;
  localparam logic [2:0] ST_ITER = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int unsigned CW = etfp_pkg::CNT_W;

  logic [2:0]                 state_q, state_d;
  logic [etfp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_ready;
  etfp_pkg::cmd_t             cmd;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          cnt_d       = '0;
          state_d     = ST_MAP;
        end
      end
      ST_MAP: begin
        // wait for the lane pipelines to deliver the start point
        if (cnt_q == etfp_pkg::MAP_LAST) begin
          cmd.iter_start = 1'b1;
          state_d        = ST_ITER;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_ITER: begin
        priority if (stat_i.esc_hit) begin
          cmd.div_start = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DIV;
        end else if (stat_i.lim_hit) begin
          state_d = ST_DONE;
        end else begin
          cmd.iter_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_q == etfp_pkg::DIV_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `ETFP_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command at once")
  `ETFP_ASSERT(a_out_free, cmd.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `ETFP_ASSERT_NEVER(a_step_past_end, cmd.iter_step && (stat_i.esc_hit || stat_i.lim_hit), "iterated past exit")
  `ETFP_ASSERT(a_div_entry, cmd.div_start |=> (state_q == ST_DIV && cnt_q == '0), "divide not started cleanly")
  `ETFP_ASSERT(a_accept_busy, (in_valid_i && in_ready) |=> !in_ready, "second request taken while busy")

endmodule

`default_nettype wire

// ===== rtl/escape_time_fractal_pixel_core.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Mandelbrot / Julia escape-time colouring of one pixel per request, Q4.28.
// ----------------------------------------------------------------------------
// One pixel request is worked on at a time. After a request is taken, the
// coordinate mapping pipeline delivers the start point, then the z*z + c
// iteration runs at one iteration per cycle through three 32x32 multipliers
// until the point escapes or reaches max_iter; for a point that escaped the
// 24-bit colour quotient follows (four quotient bits a cycle), and then the
// output register is loaded. A finished result waits in the output register
// while the next request is processed. The reset iteration limit is 64.
// Configuration is written only while no request is in flight: this binds
// the user, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_pixel_core #(
  parameter int unsigned IMG_WIDTH  = 1024,
  parameter int unsigned IMG_HEIGHT = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [etfp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [etfp_pkg::COORD_W-1:0]       pixel_x_i,
  input  wire logic [etfp_pkg::COORD_W-1:0]       pixel_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [etfp_pkg::COORD_W-1:0]            out_x_o,
  output logic [etfp_pkg::COORD_W-1:0]            out_y_o,
  output logic [etfp_pkg::COLOR_W-1:0]            pixel_color_o,
  output logic                                    escaped_o
);

  etfp_pkg::cfg_t  cfg;
  etfp_pkg::cmd_t  cmd;
  etfp_pkg::stat_t stat;

  etfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  etfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  etfp_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .pixel_color_o (pixel_color_o),
    .escaped_o     (escaped_o)
  );

endmodule

`default_nettype wire
